/* src/cnrc_pkg.sv */
package cnrc_pkg;

    localparam int REF_SLOTS       = 6;
    localparam int REF_W           = 64;
    localparam int FIELD_W         = 16;
    localparam int NUM_CHANNELS    = 4;
    localparam int THRESH_W        = 18;
    localparam int CLASS_W         = 3;
    localparam int CFG_INDEX_W     = 3;
    localparam int S_TDATA_W       = 64;
    localparam int M_TDATA_W       = 24;

    localparam logic [CFG_INDEX_W-1:0] THRESHOLD_INDEX = 3'd6;
    localparam logic [CLASS_W-1:0]     CLASS_UNKNOWN   = 3'd6;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 18'd25000;

    localparam logic [REF_SLOTS-1:0][REF_W-1:0] REFERENCE_RESET = {
        64'd1414696810754673178,
        64'd2105449593447843698,
        64'd2625051438471449232,
        64'd1763457187504259811,
        64'd1363187869333783519,
        64'd1219633350455725286
    };

    typedef struct packed {
        logic [CLASS_W-1:0]  color_class;
        logic [THRESH_W-1:0] best_distance;
    } cnrc_result_t;

endpackage

/* src/cnrc_lane.sv */
module cnrc_lane
    import cnrc_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                                      clk,
    input  logic                                      load,
    input  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] sample,
    input  logic [REF_W-1:0]                          reference,
    output logic [CHANNEL_BITS+1:0]                   distance
);

    localparam int DIST_W = CHANNEL_BITS + 2;

    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] diff;
    logic [DIST_W-1:0]                         dist_next;
    logic [DIST_W-1:0]                         dist_reg;

    always_comb
    begin
        logic [CHANNEL_BITS-1:0] r;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            r = reference[FIELD_W*k +: CHANNEL_BITS];
            diff[k] = (sample[k] > r) ? (sample[k] - r) : (r - sample[k]);
        end
    end

    assign dist_next = DIST_W'(diff[0]) + DIST_W'(diff[1]) + DIST_W'(diff[2])
                     + DIST_W'(diff[3] >> 1);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;

endmodule

/* src/cnrc_merge.sv */
module cnrc_merge
    import cnrc_pkg::*;
#(
    parameter int NUM_REFERENCES = 6,
    parameter int CHANNEL_BITS   = 16
)
(
    input  logic                                        clk,
    input  logic                                        load,
    input  logic [NUM_REFERENCES-1:0][CHANNEL_BITS+1:0] distance,
    input  logic [THRESH_W-1:0]                         threshold,
    output cnrc_result_t                                result
);

    localparam int DIST_W = CHANNEL_BITS + 2;

    cnrc_result_t result_next;
    cnrc_result_t result_reg;

    always_comb
    begin
        logic [DIST_W-1:0]  best;
        logic [CLASS_W-1:0] best_idx;
        best     = distance[0];
        best_idx = '0;
        for (int i = 1; i < NUM_REFERENCES; i++)
        begin
            if (distance[i] < best)
            begin
                best     = distance[i];
                best_idx = CLASS_W'(i);
            end
        end
        result_next.best_distance = THRESH_W'(best);
        result_next.color_class   = (THRESH_W'(best) > threshold) ? CLASS_UNKNOWN : best_idx;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* src/color_nearest_reference_classifier_core.sv */
// Nearest-reference colour classifier.
// The slave channel carries one sensor sample per transfer; tdata holds the red,
// green, blue and clear counts. The master channel returns one result per sample:
// the class (0 red to 5 yellow, 6 unknown) and the smallest weighted L1 distance.
// The references and the reject threshold are set through the write port, register
// index 0 to 5 for the references and 6 for the threshold; the user is to write
// them only while the block is idle, which the block itself does not enforce. Each
// reference is compared in a lane of its own in the first register stage, and the
// second stage picks the nearest one and applies the threshold. While the receiver
// takes results, a new sample can be taken every cycle; each stage holds one sample.
// When the receiver stalls, the result is held on the master channel and the lane
// stage can still take one more sample before s_tready falls.
// Reset empties both stages and restores the factory references and a threshold
// of 25000.
module color_nearest_reference_classifier_core
    import cnrc_pkg::*;
#(
    parameter int NUM_REFERENCES = 6,
    parameter int CHANNEL_BITS   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // red_count, green_count, blue_count, clear_count
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // color_class, best_distance, zero padding
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [REF_W-1:0]       cfg_data
);

    localparam int DIST_W = CHANNEL_BITS + 2;

    logic [REF_SLOTS-1:0][REF_W-1:0]            reference_reg;
    logic [REF_SLOTS-1:0][REF_W-1:0]            reference_next;
    logic [THRESH_W-1:0]                        threshold_reg;
    logic [THRESH_W-1:0]                        threshold_next;
    logic                                       lane_valid_reg;
    logic                                       lane_valid_next;
    logic                                       out_valid_reg;
    logic                                       out_valid_next;
    logic                                       lane_load;
    logic                                       merge_load;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0]  sample;
    logic [NUM_REFERENCES-1:0][DIST_W-1:0]      lane_distance;
    cnrc_result_t                               result;

    always_comb
    begin
        reference_next = reference_reg;
        threshold_next = threshold_reg;
        if (cfg_wr_en)
        begin
            if (cfg_index == THRESHOLD_INDEX)
            begin
                threshold_next = cfg_data[THRESH_W-1:0];
            end
            else if (cfg_index < THRESHOLD_INDEX)
            begin
                reference_next[cfg_index] = cfg_data;
            end
        end
    end

    assign merge_load = !out_valid_reg || m_tready;
    assign s_tready   = !lane_valid_reg || merge_load;
    assign lane_load  = s_tvalid && s_tready;

    assign lane_valid_next = lane_load || (lane_valid_reg && !merge_load);
    assign out_valid_next  = (merge_load && lane_valid_reg) || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_reg  <= REFERENCE_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            reference_reg  <= reference_next;
            threshold_reg  <= threshold_next;
            lane_valid_reg <= lane_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            sample[k] = s_tdata[FIELD_W*k +: CHANNEL_BITS];
        end
    end

    for (genvar i = 0; i < NUM_REFERENCES; i++)
    begin : g_lane
        cnrc_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .clk       (clk),
            .load      (lane_load),
            .sample    (sample),
            .reference (reference_reg[i]),
            .distance  (lane_distance[i])
        );
    end

    cnrc_merge #(
        .NUM_REFERENCES (NUM_REFERENCES),
        .CHANNEL_BITS   (CHANNEL_BITS)
    ) u_merge (
        .clk       (clk),
        .load      (merge_load && lane_valid_reg),
        .distance  (lane_distance),
        .threshold (threshold_reg),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CLASS_W - THRESH_W){1'b0}},
                       result.best_distance, result.color_class};

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !lane_valid_reg |-> s_tready)
        else $error("input not ready while the lane stage is empty");

    a_lane_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid_reg && merge_load) |=> m_tvalid)
        else $error("lane result lost on its way to the output");

    a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (result.color_class != CLASS_UNKNOWN))
            |-> (result.color_class < CLASS_W'(NUM_REFERENCES)))
        else $error("class names a reference that takes no part");

    a_accept_fills_lane: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> lane_valid_reg)
        else $error("accepted sample did not reach the lane stage");
`endif

endmodule
